/* rtl/lcdnq_pkg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lcdnq_pkg: shared types and constants
// Kind codes, queue sizes and the command word that travels from the front
// end to the back end of the character LCD nibble queue.
// ---------------------------------------------------------------------------
package lcdnq_pkg;

    // nibble ring store
    localparam int QUEUE_DEPTH = 256;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int ENTRY_W     = 5;
    localparam int LEVEL_W     = 9;

    // command queue between front and back
    localparam int CMDQ_DEPTH  = 2;
    localparam int CMDQ_PTR_W  = $clog2(CMDQ_DEPTH);
    localparam int CMDQ_CNT_W  = $clog2(CMDQ_DEPTH + 1);

    // input kinds
    localparam logic [1:0] KIND_COMMAND = 2'd0;
    localparam logic [1:0] KIND_DATA    = 2'd1;
    localparam logic [1:0] KIND_CURSOR  = 2'd2;
    localparam logic [1:0] KIND_TICK    = 2'd3;

    // lcd constants
    localparam logic [7:0] ROW0_BASE = 8'h80;
    localparam logic [7:0] ROW1_BASE = 8'hC0;

    typedef struct packed {
        logic       is_tick;
        logic       is_data;
        logic [7:0] payload;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } cmdq_status_t;

endpackage

/* rtl/lcdnq_ram.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lcdnq_ram: generic simple dual-port ram
// One write port, one read port with registered read data.
// ---------------------------------------------------------------------------
module lcdnq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/lcdnq_front.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lcdnq_front: input classifier
// Accepts items, turns cursor positions into set-address commands and hands
// one command word per transfer to the command queue.
// ---------------------------------------------------------------------------
module lcdnq_front (
    input  logic                  start,
    output logic                  busy,
    input  logic [1:0]            kind,
    input  logic [7:0]            value,
    input  logic                  row,
    input  logic [5:0]            column,
    input  lcdnq_pkg::cmdq_status_t q_status,
    output logic                  push_valid,
    output lcdnq_pkg::cmd_t       push_cmd
);

    logic [7:0] cursor_byte;

    assign busy       = q_status.full;
    assign push_valid = start && !q_status.full;

    // base plus a 6-bit column never carries out of 8 bits
    assign cursor_byte = (row ? lcdnq_pkg::ROW1_BASE : lcdnq_pkg::ROW0_BASE)
                         + {2'b00, column};

    always_comb
    begin
        push_cmd = '0;
        unique case (kind)
            lcdnq_pkg::KIND_COMMAND:
            begin
                push_cmd.payload = value;
            end
            lcdnq_pkg::KIND_DATA:
            begin
                push_cmd.is_data = 1'b1;
                push_cmd.payload = value;
            end
            lcdnq_pkg::KIND_CURSOR:
            begin
                push_cmd.payload = cursor_byte;
            end
            lcdnq_pkg::KIND_TICK:
            begin
                push_cmd.is_tick = 1'b1;
            end
            default:
            begin
                push_cmd = '0;
            end
        endcase
    end

endmodule

/* rtl/lcdnq_cmdq.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lcdnq_cmdq: command queue
// Short flop-based fifo that lets the front end take items while the back
// end is still writing or reading the nibble store.
// ---------------------------------------------------------------------------
module lcdnq_cmdq (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    input  lcdnq_pkg::cmd_t         push_cmd,
    input  logic                    pop,
    output lcdnq_pkg::cmd_t         head,
    output lcdnq_pkg::cmdq_status_t status
);

    lcdnq_pkg::cmd_t                   entries_reg [lcdnq_pkg::CMDQ_DEPTH];
    logic [lcdnq_pkg::CMDQ_PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [lcdnq_pkg::CMDQ_PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [lcdnq_pkg::CMDQ_CNT_W-1:0]  count_reg, count_next;
    logic                              do_push, do_pop;

    localparam logic [lcdnq_pkg::CMDQ_PTR_W-1:0] LAST_IDX =
        lcdnq_pkg::CMDQ_PTR_W'(lcdnq_pkg::CMDQ_DEPTH - 1);
    localparam logic [lcdnq_pkg::CMDQ_CNT_W-1:0] FULL_CNT =
        lcdnq_pkg::CMDQ_CNT_W'(lcdnq_pkg::CMDQ_DEPTH);

    assign status.full  = (count_reg == FULL_CNT);
    assign status.empty = (count_reg == '0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign head         = entries_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_IDX) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_IDX) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entries_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

/* rtl/lcdnq_back.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lcdnq_back: nibble store sequencer
// Splits queued bytes into two tagged nibbles written to the ring store and
// serves ticks by reading the oldest nibble into the result registers, or idle if empty.
// ---------------------------------------------------------------------------
module lcdnq_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  lcdnq_pkg::cmd_t             head,
    input  lcdnq_pkg::cmdq_status_t     q_status,
    output logic                        pop,
    output logic                        done,
    output logic [3:0]                  nibble,
    output logic                        register_select,
    output logic                        enable_pulse,
    output logic [lcdnq_pkg::LEVEL_W-1:0] queue_level
);

    localparam logic [1:0] ST_IDLE    = 2'd0;
    localparam logic [1:0] ST_PUSH_LO = 2'd1;
    localparam logic [1:0] ST_TICK_RD = 2'd2;

    localparam logic [lcdnq_pkg::PTR_W-1:0] LAST_PTR =
        lcdnq_pkg::PTR_W'(lcdnq_pkg::QUEUE_DEPTH - 1);
    localparam logic [lcdnq_pkg::CNT_W-1:0] PUSH_LIMIT =
        lcdnq_pkg::CNT_W'(lcdnq_pkg::QUEUE_DEPTH - 2);

    logic [1:0]                         state_reg, state_next;
    logic [lcdnq_pkg::PTR_W-1:0]        wp_reg, wp_next;
    logic [lcdnq_pkg::PTR_W-1:0]        rp_reg, rp_next;
    logic [lcdnq_pkg::CNT_W-1:0]        count_reg, count_next;
    logic [lcdnq_pkg::ENTRY_W-1:0]      lo_reg, lo_next;
    logic                               done_reg, done_next;
    logic [3:0]                         nibble_reg, nibble_next;
    logic                               rs_reg, rs_next;
    logic                               en_reg, en_next;
    logic [lcdnq_pkg::LEVEL_W-1:0]      level_reg, level_next;

    logic                               ram_we, ram_re;
    logic [lcdnq_pkg::PTR_W-1:0]        ram_waddr;
    logic [lcdnq_pkg::ENTRY_W-1:0]      ram_wdata, ram_rdata;

    lcdnq_ram #(
        .WIDTH (lcdnq_pkg::ENTRY_W),
        .DEPTH (lcdnq_pkg::QUEUE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (rp_reg),
        .rdata (ram_rdata)
    );

    assign ram_waddr = wp_reg;
    assign pop       = (state_reg == ST_IDLE) && !q_status.empty;

    always_comb
    begin
        state_next  = state_reg;
        wp_next     = wp_reg;
        rp_next     = rp_reg;
        count_next  = count_reg;
        lo_next     = lo_reg;
        done_next   = 1'b0;
        nibble_next = nibble_reg;
        rs_next     = rs_reg;
        en_next     = en_reg;
        level_next  = level_reg;
        ram_we      = 1'b0;
        ram_re      = 1'b0;
        ram_wdata   = lo_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (pop)
                begin
                    if (head.is_tick)
                    begin
                        if (count_reg == '0)
                        begin
                            // empty queue: idle result right away
                            done_next   = 1'b1;
                            nibble_next = '0;
                            rs_next     = 1'b0;
                            en_next     = 1'b0;
                            level_next  = '0;
                        end
                        else
                        begin
                            ram_re     = 1'b1;
                            rp_next    = (rp_reg == LAST_PTR) ? '0 : rp_reg + 1'b1;
                            count_next = count_reg - 1'b1;
                            state_next = ST_TICK_RD;
                        end
                    end
                    else if (count_reg <= PUSH_LIMIT)
                    begin
                        // high nibble now, low nibble next cycle
                        ram_we     = 1'b1;
                        ram_wdata  = {head.is_data, head.payload[7:4]};
                        lo_next    = {head.is_data, head.payload[3:0]};
                        wp_next    = (wp_reg == LAST_PTR) ? '0 : wp_reg + 1'b1;
                        count_next = count_reg + 1'b1;
                        state_next = ST_PUSH_LO;
                    end
                end
            end
            ST_PUSH_LO:
            begin
                ram_we     = 1'b1;
                ram_wdata  = lo_reg;
                wp_next    = (wp_reg == LAST_PTR) ? '0 : wp_reg + 1'b1;
                count_next = count_reg + 1'b1;
                state_next = ST_IDLE;
            end
            ST_TICK_RD:
            begin
                done_next   = 1'b1;
                nibble_next = ram_rdata[3:0];
                rs_next     = ram_rdata[4];
                en_next     = 1'b1;
                level_next  = lcdnq_pkg::LEVEL_W'(count_reg);
                state_next  = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            wp_reg    <= '0;
            rp_reg    <= '0;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            wp_reg    <= wp_next;
            rp_reg    <= rp_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg     <= lo_next;
        nibble_reg <= nibble_next;
        rs_reg     <= rs_next;
        en_reg     <= en_next;
        level_reg  <= level_next;
    end

    assign done            = done_reg;
    assign nibble          = nibble_reg;
    assign register_select = rs_reg;
    assign enable_pulse    = en_reg;
    assign queue_level     = level_reg;

    // store never holds more than its depth
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= lcdnq_pkg::CNT_W'(lcdnq_pkg::QUEUE_DEPTH))
        else $error("nibble count exceeds store depth");

    // a read issued for a tick always comes back as a strobed result
    a_tick_result: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_TICK_RD |=> done_reg && en_reg)
        else $error("tick read did not produce a strobed result");

    // low nibble write only ever follows the high nibble write
    a_push_order: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_PUSH_LO |-> $past(state_reg == ST_IDLE))
        else $error("low nibble write without high nibble");

    // an idle tick reports an empty queue
    a_idle_tick: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg && !en_reg |-> level_reg == '0 && nibble_reg == '0)
        else $error("idle tick with nonzero fields");

    // no new command is taken while a byte or tick is mid-flight
    a_no_pop_busy: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != ST_IDLE |-> !pop)
        else $error("command popped while sequencer busy");

endmodule

/* rtl/character_lcd_nibble_queue.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// character_lcd_nibble_queue: 4-bit character lcd write queue
// Queues command, data and cursor bytes as tagged nibbles in a ring store and
// pops one nibble per tick onto the lcd pin values.
//
//   channel   handshake        payload
//   -------   --------------   ---------------------------------------------
//   input     start / busy     kind, value, row, column
//   result    done (strobe)    nibble, register_select, enable_pulse,
//                              queue_level
//
// a byte push makes two writes into the single-write-port nibble store in the
// back end; a tick reads the store through its registered read port, and an
// idle tick skips the read. a two-entry command queue lets the front end take
// items while the back end works; busy is high while that queue is full.
// reset clears pointers, counts and control; the store needs no clearing.
// a tick result shows on the ports when done rises and stays there until the
// next tick result; the receiver cannot stall it.
// ---------------------------------------------------------------------------
module character_lcd_nibble_queue (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [1:0]                    kind,
    input  logic [7:0]                    value,
    input  logic                          row,
    input  logic [5:0]                    column,
    output logic                          done,
    output logic [3:0]                    nibble,
    output logic                          register_select,
    output logic                          enable_pulse,
    output logic [lcdnq_pkg::LEVEL_W-1:0] queue_level
);

    lcdnq_pkg::cmdq_status_t q_status;
    lcdnq_pkg::cmd_t         push_cmd;
    lcdnq_pkg::cmd_t         head;
    logic                    push_valid;
    logic                    pop;

    lcdnq_front u_front (
        .start      (start),
        .busy       (busy),
        .kind       (kind),
        .value      (value),
        .row        (row),
        .column     (column),
        .q_status   (q_status),
        .push_valid (push_valid),
        .push_cmd   (push_cmd)
    );

    lcdnq_cmdq u_cmdq (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push_valid),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (head),
        .status   (q_status)
    );

    lcdnq_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .head            (head),
        .q_status        (q_status),
        .pop             (pop),
        .done            (done),
        .nibble          (nibble),
        .register_select (register_select),
        .enable_pulse    (enable_pulse),
        .queue_level     (queue_level)
    );

endmodule

/* dv/testbench.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench: character_lcd_nibble_queue
// Drives command, data, cursor and tick transfers through start / busy with
// random gaps. A local model of the nibble ring predicts every tick result,
// and each done strobe is checked in order against that prediction, or against the
// hand-read pins of a typed table row. A short table covers the edge cases, a fill
// phase hits the full-queue drop, and random phases swing the queue level up and down.
// ---------------------------------------------------------------------------
module testbench;

    localparam logic [1:0] KIND_COMMAND = lcdnq_pkg::KIND_COMMAND;
    localparam logic [1:0] KIND_DATA    = lcdnq_pkg::KIND_DATA;
    localparam logic [1:0] KIND_CURSOR  = lcdnq_pkg::KIND_CURSOR;
    localparam logic [1:0] KIND_TICK    = lcdnq_pkg::KIND_TICK;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] value;
        logic       row;
        logic [5:0] column;
    } lcd_req_t;

    typedef struct packed {
        logic [3:0]                    nib;
        logic                          rs;
        logic                          en;
        logic [lcdnq_pkg::LEVEL_W-1:0] level;
    } lcd_pins_t;

    typedef struct packed {
        lcd_req_t  req;
        logic      typed;
        lcd_pins_t pins;
    } lcd_row_t;

    logic                          clk = 1'b0;
    logic                          rst_n;
    logic                          start;
    logic                          busy;
    logic [1:0]                    kind;
    logic [7:0]                    value;
    logic                          row;
    logic [5:0]                    column;
    logic                          done;
    logic [3:0]                    nibble;
    logic                          register_select;
    logic                          enable_pulse;
    logic [lcdnq_pkg::LEVEL_W-1:0] queue_level;

    // local copy of the nibble ring
    logic [lcdnq_pkg::ENTRY_W-1:0] ring_mem [lcdnq_pkg::QUEUE_DEPTH];
    logic [lcdnq_pkg::PTR_W-1:0]   ring_wr;
    logic [lcdnq_pkg::PTR_W-1:0]   ring_rd;
    int                            ring_fill;

    lcd_pins_t pins_q [$];
    lcd_pins_t exp_pins;
    lcd_row_t  stim_tbl [$];

    int errors       = 0;
    int n_items      = 0;
    int n_strobes    = 0;
    int n_idle_ticks = 0;
    int n_dropped    = 0;

    character_lcd_nibble_queue u_top (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .kind            (kind),
        .value           (value),
        .row             (row),
        .column          (column),
        .done            (done),
        .nibble          (nibble),
        .register_select (register_select),
        .enable_pulse    (enable_pulse),
        .queue_level     (queue_level)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #5_000_000;
        $display("timeout at %0t with %0d results pending", $time, pins_q.size());
        $display("FAIL");
        $finish;
    end

    // returns 1 when the item yields a result
    function automatic bit lcd_predict(input lcd_req_t r, output lcd_pins_t p);
        logic [7:0] byte_val;
        logic       tag;
        logic [4:0] entry;
        p = '0;
        if (r.kind == KIND_TICK)
        begin
            if (ring_fill == 0)
            begin
                n_idle_ticks++;
                return 1'b1;
            end
            entry     = ring_mem[ring_rd];
            ring_rd   = ring_rd + 1'b1;
            ring_fill = ring_fill - 1;
            p.nib     = entry[3:0];
            p.rs      = entry[4];
            p.en      = 1'b1;
            p.level   = ring_fill[lcdnq_pkg::LEVEL_W-1:0];
            return 1'b1;
        end
        if (r.kind == KIND_CURSOR)
            byte_val = (r.row ? lcdnq_pkg::ROW1_BASE : lcdnq_pkg::ROW0_BASE)
                       + {2'b00, r.column};
        else
            byte_val = r.value;
        tag = (r.kind == KIND_DATA);
        // a byte needs two free slots or it is dropped whole
        if (ring_fill + 2 > lcdnq_pkg::QUEUE_DEPTH)
        begin
            n_dropped++;
            return 1'b0;
        end
        ring_mem[ring_wr] = {tag, byte_val[7:4]};
        ring_wr           = ring_wr + 1'b1;
        ring_mem[ring_wr] = {tag, byte_val[3:0]};
        ring_wr           = ring_wr + 1'b1;
        ring_fill         = ring_fill + 2;
        return 1'b0;
    endfunction

    function automatic lcd_row_t tbl_row(input logic [1:0] k, input logic [7:0] v,
                                         input logic r, input logic [5:0] c,
                                         input logic typed, input logic [3:0] nib,
                                         input logic rs, input logic en,
                                         input logic [lcdnq_pkg::LEVEL_W-1:0] level);
        lcd_row_t t;
        t.req   = '{kind: k, value: v, row: r, column: c};
        t.typed = typed;
        t.pins  = '{nib: nib, rs: rs, en: en, level: level};
        return t;
    endfunction

    function automatic lcd_row_t rand_row(input int tick_pct);
        lcd_row_t t;
        t = '0;
        if ($urandom_range(0, 99) < tick_pct)
            t.req.kind = KIND_TICK;
        else
            t.req.kind = 2'($urandom_range(0, 2));
        t.req.value  = 8'($urandom);
        t.req.row    = 1'($urandom);
        t.req.column = 6'($urandom);
        return t;
    endfunction

    // one transfer: hold start until busy is low at a rising edge
    task automatic send_item(input lcd_row_t t);
        lcd_pins_t p;
        start  = 1'b1;
        kind   = t.req.kind;
        value  = t.req.value;
        row    = t.req.row;
        column = t.req.column;
        do
            @(posedge clk);
        while (busy);
        if (lcd_predict(t.req, p))
            pins_q.push_back(t.typed ? t.pins : p);
        n_items++;
        @(negedge clk);
        start = 1'b0;
    endtask

    task automatic idle_gap(input bit quiet);
        int r;
        int n;
        r = $urandom_range(0, 99);
        if (quiet || r < 60)
            n = 0;
        else if (r < 92)
            n = $urandom_range(1, 3);
        else
            n = $urandom_range(8, 40);
        repeat (n) @(negedge clk);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && done === 1'b1)
        begin
            n_strobes++;
            if (pins_q.size() == 0)
            begin
                errors++;
                $display("%0t: result with none expected: nib %h rs %b en %b level %0d",
                         $time, nibble, register_select, enable_pulse, queue_level);
            end
            else
            begin
                exp_pins = pins_q.pop_front();
                if (nibble !== exp_pins.nib || register_select !== exp_pins.rs ||
                    enable_pulse !== exp_pins.en || queue_level !== exp_pins.level)
                begin
                    errors++;
                    $display({"%0t: expected nib %h rs %b en %b level %0d,",
                              " got nib %h rs %b en %b level %0d"},
                             $time, exp_pins.nib, exp_pins.rs, exp_pins.en,
                             exp_pins.level, nibble, register_select, enable_pulse,
                             queue_level);
                end
            end
        end
    end

    initial
    begin
        int tick_pct;
        bit quiet;
        lcd_row_t t;

        rst_n     = 1'b0;
        start     = 1'b0;
        kind      = KIND_COMMAND;
        value     = '0;
        row       = 1'b0;
        column    = '0;
        ring_wr   = '0;
        ring_rd   = '0;
        ring_fill = 0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // edge cases with hand-read results where obvious
        stim_tbl.push_back(tbl_row(KIND_TICK,    8'h00, 1'b0, 6'd0,  1'b1, 4'h0, 1'b0, 1'b0, 9'd0));
        stim_tbl.push_back(tbl_row(KIND_COMMAND, 8'h00, 1'b1, 6'd63, 1'b0, 4'h0, 1'b0, 1'b0, 9'd0));
        stim_tbl.push_back(tbl_row(KIND_TICK,    8'hFF, 1'b1, 6'd63, 1'b1, 4'h0, 1'b0, 1'b1, 9'd1));
        stim_tbl.push_back(tbl_row(KIND_TICK,    8'h00, 1'b0, 6'd0,  1'b1, 4'h0, 1'b0, 1'b1, 9'd0));
        stim_tbl.push_back(tbl_row(KIND_DATA,    8'hFF, 1'b0, 6'd0,  1'b0, 4'h0, 1'b0, 1'b0, 9'd0));
        stim_tbl.push_back(tbl_row(KIND_TICK,    8'h00, 1'b0, 6'd0,  1'b1, 4'hF, 1'b1, 1'b1, 9'd1));
        stim_tbl.push_back(tbl_row(KIND_TICK,    8'h00, 1'b0, 6'd0,  1'b1, 4'hF, 1'b1, 1'b1, 9'd0));
        stim_tbl.push_back(tbl_row(KIND_CURSOR,  8'hFF, 1'b0, 6'd0,  1'b0, 4'h0, 1'b0, 1'b0, 9'd0));
        stim_tbl.push_back(tbl_row(KIND_CURSOR,  8'h00, 1'b1, 6'd63, 1'b0, 4'h0, 1'b0, 1'b0, 9'd0));
        stim_tbl.push_back(tbl_row(KIND_DATA,    8'hA5, 1'b1, 6'd21, 1'b0, 4'h0, 1'b0, 1'b0, 9'd0));
        stim_tbl.push_back(tbl_row(KIND_TICK,    8'h00, 1'b0, 6'd0,  1'b1, 4'h8, 1'b0, 1'b1, 9'd5));
        stim_tbl.push_back(tbl_row(KIND_TICK,    8'h00, 1'b0, 6'd0,  1'b1, 4'h0, 1'b0, 1'b1, 9'd4));
        stim_tbl.push_back(tbl_row(KIND_TICK,    8'h00, 1'b0, 6'd0,  1'b1, 4'hF, 1'b0, 1'b1, 9'd3));
        stim_tbl.push_back(tbl_row(KIND_TICK,    8'h00, 1'b0, 6'd0,  1'b1, 4'hF, 1'b0, 1'b1, 9'd2));
        stim_tbl.push_back(tbl_row(KIND_TICK,    8'h00, 1'b0, 6'd0,  1'b1, 4'hA, 1'b1, 1'b1, 9'd1));
        stim_tbl.push_back(tbl_row(KIND_TICK,    8'h00, 1'b0, 6'd0,  1'b1, 4'h5, 1'b1, 1'b1, 9'd0));
        stim_tbl.push_back(tbl_row(KIND_TICK,    8'hFF, 1'b1, 6'd63, 1'b1, 4'h0, 1'b0, 1'b0, 9'd0));
        stim_tbl.push_back(tbl_row(KIND_COMMAND, 8'h5A, 1'b0, 6'd42, 1'b0, 4'h0, 1'b0, 1'b0, 9'd0));
        stim_tbl.push_back(tbl_row(KIND_CURSOR,  8'h3C, 1'b1, 6'd21, 1'b0, 4'h0, 1'b0, 1'b0, 9'd0));
        repeat (4)
            stim_tbl.push_back(tbl_row(KIND_TICK, 8'h00, 1'b0, 6'd0, 1'b0, 4'h0, 1'b0, 1'b0, 9'd0));

        foreach (stim_tbl[i])
        begin
            send_item(stim_tbl[i]);
            idle_gap(1'b0);
        end

        // fill to the brim: the 129th byte and the one with a single slot free are dropped
        for (int i = 0; i < 133; i++)
        begin
            if (i == 129 || i == 131)
                t = rand_row(100);
            else
                t = rand_row(0);
            send_item(t);
            idle_gap(i < 64);
        end
        // drain down to half full
        while (ring_fill > lcdnq_pkg::QUEUE_DEPTH / 2)
        begin
            send_item(rand_row(100));
            idle_gap(1'b0);
        end

        // random phases with shifting tick rates so the level swings
        for (int ph = 0; ph < 6; ph++)
        begin
            case ($urandom_range(0, 4))
                0: tick_pct = 10;
                1: tick_pct = 30;
                2: tick_pct = 50;
                3: tick_pct = 70;
                default: tick_pct = 90;
            endcase
            quiet = ($urandom_range(0, 2) == 0);
            for (int i = 0; i < 28; i++)
            begin
                send_item(rand_row(tick_pct));
                idle_gap(quiet);
            end
        end

        while (pins_q.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        $display("sent %0d items, checked %0d tick results (%0d idle)", n_items, n_strobes,
                 n_idle_ticks);
        $display("%0d bytes dropped on a full queue, %0d mismatches", n_dropped, errors);
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

/* files.f */
rtl/lcdnq_pkg.sv
rtl/lcdnq_ram.sv
rtl/lcdnq_front.sv
rtl/lcdnq_cmdq.sv
rtl/lcdnq_back.sv
rtl/character_lcd_nibble_queue.sv
dv/testbench.sv
